@@ src/gdm_pkg.sv @@
// ----------------------------------------------------------------------------
// gdm_pkg: shared constants and calendar tables
// constants, reciprocal for the divide by 100, and month lookup functions
// ----------------------------------------------------------------------------
package gdm_pkg;

   localparam int unsigned YEAR_W     = 14;
   localparam int unsigned MONTH_W    = 4;
   localparam int unsigned DAY_W      = 5;
   localparam int unsigned HOUR_W     = 5;
   localparam int unsigned MINUTE_W   = 6;
   localparam int unsigned ELAPSED_W  = 32;

   localparam int unsigned FIRST_YEAR = 1900;
   localparam int unsigned LAST_YEAR  = 9999;

   // n / 100 == (n * RECIP_100) >> RECIP_SHIFT for every 14-bit n
   localparam int unsigned RECIP_100   = 5243;
   localparam int unsigned RECIP_W     = 13;
   localparam int unsigned RECIP_SHIFT = 19;
   localparam int unsigned PROD_W      = YEAR_W + RECIP_W;
   localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;

   // leap years among years 1..1899
   localparam int unsigned LEAPS_BEFORE_FIRST = 460;

   localparam int unsigned DAYS_W      = 22;
   localparam int unsigned DAY_MIN_W   = 11;
   localparam int unsigned DBM_W       = 9;
   localparam int unsigned MIN_PER_DAY = 1440;
   localparam int unsigned MIN_PER_HR  = 60;

   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // length of a month in a common year, zero for codes that are no month
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

   // days in the common year before the first of the month
   function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [DBM_W-1:0] dbm;
      unique case (m)
         4'd2:    dbm = 9'd31;
         4'd3:    dbm = 9'd59;
         4'd4:    dbm = 9'd90;
         4'd5:    dbm = 9'd120;
         4'd6:    dbm = 9'd151;
         4'd7:    dbm = 9'd181;
         4'd8:    dbm = 9'd212;
         4'd9:    dbm = 9'd243;
         4'd10:   dbm = 9'd273;
         4'd11:   dbm = 9'd304;
         4'd12:   dbm = 9'd334;
         default: dbm = 9'd0;
      endcase
      return dbm;
   endfunction

endpackage

@@ src/gregorian_datetime_to_minutes.sv @@
// ----------------------------------------------------------------------------
// gregorian_datetime_to_minutes: calendar timestamp to minutes since 1900
// validates year/month/day/hour/minute and counts minutes from 1900-01-01
// ----------------------------------------------------------------------------
// throughput: one item per cycle unless the output stalls; four register stages,
//   each with its own valid bit, so a stalled output only holds stages that are occupied
// reset: synchronous, active high; clears all stage valid bits, payload
//   registers are not reset
// ----------------------------------------------------------------------------
module gregorian_datetime_to_minutes (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [gdm_pkg::YEAR_W-1:0]        req_year,
   input  logic [gdm_pkg::MONTH_W-1:0]       req_month,
   input  logic [gdm_pkg::DAY_W-1:0]         req_day,
   input  logic [gdm_pkg::HOUR_W-1:0]        req_hour,
   input  logic [gdm_pkg::MINUTE_W-1:0]      req_minute,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_is_valid,
   output logic [gdm_pkg::ELAPSED_W-1:0]     rsp_elapsed_minutes
);

   localparam int unsigned YW = gdm_pkg::YEAR_W;
   localparam int unsigned PW = gdm_pkg::PROD_W;
   localparam int unsigned QW = gdm_pkg::QUOT_W;
   localparam int unsigned DW = gdm_pkg::DAYS_W;
   localparam int unsigned MW = gdm_pkg::DAY_MIN_W;

   // ---------------------------------------------------------------------------
   // stage enables: a stage loads when it is empty or its successor moves on
   // ---------------------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_en, s2_en, s3_en, s4_en;

   assign s4_en     = !rsp_valid_ff || !rsp_stall;
   assign s3_en     = !s3_valid_ff  || s4_en;
   assign s2_en     = !s2_valid_ff  || s3_en;
   assign s1_en     = !s1_valid_ff  || s2_en;
   assign req_stall = !s1_en;

   // ---------------------------------------------------------------------------
   // stage 1: field range checks, reciprocal products for y/100 and (y-1)/100
   // ---------------------------------------------------------------------------
   logic [YW-1:0]                      s1_year_ff;
   logic [gdm_pkg::MONTH_W-1:0]        s1_month_ff;
   logic [gdm_pkg::DAY_W-1:0]          s1_day_ff;
   logic [gdm_pkg::HOUR_W-1:0]         s1_hour_ff;
   logic [gdm_pkg::MINUTE_W-1:0]       s1_minute_ff;
   logic                               s1_ok_ff, s1_ok_in;
   logic [PW-1:0]                      s1_prod_y_ff, s1_prod_y_in;
   logic [PW-1:0]                      s1_prod_n_ff, s1_prod_n_in;

   always_comb begin
      s1_ok_in = (req_year >= YW'(gdm_pkg::FIRST_YEAR))
              && (req_year <= YW'(gdm_pkg::LAST_YEAR))
              && (req_month != '0)
              && (req_month <= gdm_pkg::MONTH_DEC)
              && (req_hour <= gdm_pkg::HOUR_W'(23))
              && (req_minute <= gdm_pkg::MINUTE_W'(59));
      s1_prod_y_in = PW'(req_year) * PW'(gdm_pkg::RECIP_100);
      s1_prod_n_in = PW'(req_year - YW'(1)) * PW'(gdm_pkg::RECIP_100);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_valid;
      end
      if (s1_en) begin
         s1_year_ff   <= req_year;
         s1_month_ff  <= req_month;
         s1_day_ff    <= req_day;
         s1_hour_ff   <= req_hour;
         s1_minute_ff <= req_minute;
         s1_ok_ff     <= s1_ok_in;
         s1_prod_y_ff <= s1_prod_y_in;
         s1_prod_n_ff <= s1_prod_n_in;
      end
   end

   // ---------------------------------------------------------------------------
   // stage 2: leap-year test, leap count since 1900, day-of-month check
   // ---------------------------------------------------------------------------
   logic [QW-1:0]                      q_y, q_n;
   logic [YW-1:0]                      n_year;
   logic [YW:0]                        q_y_x100;
   logic                               is_leap;
   logic [gdm_pkg::DAY_W-1:0]          mlen;

   logic [YW-1:0]                      s2_year_ff;
   logic [gdm_pkg::MONTH_W-1:0]        s2_month_ff;
   logic [gdm_pkg::DAY_W-1:0]          s2_day_ff;
   logic [gdm_pkg::HOUR_W-1:0]         s2_hour_ff;
   logic [gdm_pkg::MINUTE_W-1:0]       s2_minute_ff;
   logic                               s2_ok_ff, s2_ok_in;
   logic                               s2_leap_ff;
   logic [YW-1:0]                      s2_leaps_ff, s2_leaps_in;

   always_comb begin
      q_y      = s1_prod_y_ff[PW-1:gdm_pkg::RECIP_SHIFT];
      q_n      = s1_prod_n_ff[PW-1:gdm_pkg::RECIP_SHIFT];
      n_year   = s1_year_ff - YW'(1);
      q_y_x100 = (YW+1)'(q_y) * (YW+1)'(100);
      // divisible by 4 and not by 100, or divisible by 400
      if (q_y_x100 == {1'b0, s1_year_ff}) begin
         is_leap = (q_y[1:0] == 2'b00);
      end else begin
         is_leap = (s1_year_ff[1:0] == 2'b00);
      end
      mlen = gdm_pkg::month_len(s1_month_ff);
      if (s1_month_ff == gdm_pkg::MONTH_FEB && is_leap) begin
         mlen = gdm_pkg::DAY_W'(29);
      end
      s2_ok_in = s1_ok_ff && (s1_day_ff != '0) && (s1_day_ff <= mlen);
      // leaps among years 1900..y-1; wraps only for years that are rejected
      s2_leaps_in = (n_year >> 2) - YW'(q_n) + YW'(q_n >> 2)
                  - YW'(gdm_pkg::LEAPS_BEFORE_FIRST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_en) begin
         s2_year_ff   <= s1_year_ff;
         s2_month_ff  <= s1_month_ff;
         s2_day_ff    <= s1_day_ff;
         s2_hour_ff   <= s1_hour_ff;
         s2_minute_ff <= s1_minute_ff;
         s2_ok_ff     <= s2_ok_in;
         s2_leap_ff   <= is_leap;
         s2_leaps_ff  <= s2_leaps_in;
      end
   end

   // ---------------------------------------------------------------------------
   // stage 3: day count since 1900-01-01 and minute of the day
   // ---------------------------------------------------------------------------
   logic [YW-1:0]                      year_ofs;
   logic [DW:0]                        year_days;
   logic [DW:0]                        days_sum;
   logic                               s3_ok_ff;
   logic [DW-1:0]                      s3_days_ff, s3_days_in;
   logic [MW-1:0]                      s3_mod_ff, s3_mod_in;

   always_comb begin
      year_ofs  = s2_year_ff - YW'(gdm_pkg::FIRST_YEAR);
      year_days = (DW+1)'(year_ofs) * (DW+1)'(365);
      days_sum  = year_days
                + (DW+1)'(s2_leaps_ff)
                + (DW+1)'(gdm_pkg::days_before_month(s2_month_ff))
                + (DW+1)'(s2_day_ff - gdm_pkg::DAY_W'(1));
      // leap day already behind us from March on
      if (s2_month_ff > gdm_pkg::MONTH_FEB && s2_leap_ff) begin
         days_sum = days_sum + (DW+1)'(1);
      end
      s3_days_in = days_sum[DW-1:0];
      s3_mod_in  = MW'(s2_hour_ff) * MW'(gdm_pkg::MIN_PER_HR) + MW'(s2_minute_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_en) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s3_en) begin
         s3_ok_ff   <= s2_ok_ff;
         s3_days_ff <= s3_days_in;
         s3_mod_ff  <= s3_mod_in;
      end
   end

   // ---------------------------------------------------------------------------
   // stage 4: days * 1440 + minute of day into the output register
   // ---------------------------------------------------------------------------
   logic [DW+MW-1:0]                   total;
   logic                               rsp_is_valid_ff;
   logic [gdm_pkg::ELAPSED_W-1:0]      rsp_elapsed_ff, rsp_elapsed_in;

   always_comb begin
      total = (DW+MW)'(s3_days_ff) * (DW+MW)'(gdm_pkg::MIN_PER_DAY) + (DW+MW)'(s3_mod_ff);
      rsp_elapsed_in = s3_ok_ff ? total[gdm_pkg::ELAPSED_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s4_en) begin
         rsp_valid_ff <= s3_valid_ff;
      end
      if (s4_en) begin
         rsp_is_valid_ff <= s3_ok_ff;
         rsp_elapsed_ff  <= rsp_elapsed_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_is_valid        = rsp_is_valid_ff;
   assign rsp_elapsed_minutes = rsp_elapsed_ff;

   // ---------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------
   // an invalid timestamp always reports zero minutes
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_valid) |-> (rsp_elapsed_minutes == '0))
      else $error("invalid timestamp with nonzero minute count");

   // input is only held off when every stage is full and the output is stalled
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && s1_valid_ff && s2_valid_ff && s3_valid_ff))
      else $error("input stalled while the pipeline has room");

   // reset empties the output stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // a stalled stage 3 item is not lost: stage 3 holds while stage 4 cannot move
   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !s4_en) |=> (s3_valid_ff && $stable(s3_days_ff)))
      else $error("stage 3 item dropped during stall");

endmodule
